/* rtl/core/cook_timer_duty_cycle_controller_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef COOK_TIMER_DUTY_CYCLE_CONTROLLER_CORE_DEFINES_SVH
`define COOK_TIMER_DUTY_CYCLE_CONTROLLER_CORE_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define CTDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CTDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ctdc_pkg.sv */
package ctdc_pkg;

  localparam int WINDOW_SEC = 10;
  localparam int WIN_W      = $clog2(WINDOW_SEC);
  localparam int TIME_W     = 17;
  localparam int POWER_W    = 7;
  localparam int PERCENT    = 100;
  localparam int ROUND_HALF = 50;
  // Wide enough for power * WINDOW_SEC + ROUND_HALF and for (pos + 1) * PERCENT.
  localparam int ONL_W      = $clog2(PERCENT * WINDOW_SEC + ROUND_HALF + 1);

  localparam logic [TIME_W-1:0]  MAX_COOK_RESET  = TIME_W'(1800);
  localparam logic [TIME_W-1:0]  REMAINING_RESET = TIME_W'(30);
  localparam logic [POWER_W-1:0] POWER_FULL      = POWER_W'(100);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_MODIFY = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4,
    OP_PAUSE  = 3'd5,
    OP_RESUME = 3'd6,
    OP_MODE   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    RS_STOPPED = 3'b001,
    RS_RUNNING = 3'b010,
    RS_PAUSED  = 3'b100
  } run_state_t;

  localparam logic [1:0] RUN_CODE_STOPPED = 2'd0;
  localparam logic [1:0] RUN_CODE_RUNNING = 2'd1;
  localparam logic [1:0] RUN_CODE_PAUSED  = 2'd2;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    opcode_t              opcode;
    logic                 cook_mode;
    logic [TIME_W-1:0]    cook_time;
    logic [POWER_W-1:0]   power_level;
    logic                 power_given;
    logic                 start_after;
  } cmd_t;

  typedef struct packed {
    run_state_t           run;
    logic [TIME_W-1:0]    remaining;
    logic [WIN_W-1:0]     duty_phase;
    logic                 mode;
    logic [POWER_W-1:0]   power;
    logic                 relay;
  } state_t;

  localparam state_t STATE_RESET = '{
    run:        RS_STOPPED,
    remaining:  REMAINING_RESET,
    duty_phase: '0,
    mode:       1'b0,
    power:      POWER_FULL,
    relay:      1'b0
  };

  function automatic logic [1:0] run_code(input run_state_t rs);
    logic [1:0] code;
    case (rs)
      RS_STOPPED: code = RUN_CODE_STOPPED;
      RS_RUNNING: code = RUN_CODE_RUNNING;
      RS_PAUSED:  code = RUN_CODE_PAUSED;
      default:    code = RUN_CODE_STOPPED;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/ctdc_if.sv */
interface ctdc_cmd_if;
  import ctdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic                 cook_mode;
  logic [TIME_W-1:0]    cook_time;
  logic [POWER_W-1:0]   power_level;
  logic                 power_given;
  logic                 start_after;

  modport source (
    output valid, opcode, cook_mode, cook_time, power_level, power_given, start_after,
    input  ready
  );

  modport sink (
    input  valid, opcode, cook_mode, cook_time, power_level, power_given, start_after,
    output ready
  );
endinterface

interface ctdc_rsp_if;
  import ctdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           run_state;
  logic                 relay_on;
  logic [TIME_W-1:0]    seconds_left;
  logic                 mode_now;
  logic [POWER_W-1:0]   power_now;
  logic                 completed;
  logic                 status;

  modport source (
    output valid, run_state, relay_on, seconds_left, mode_now, power_now, completed, status,
    input  ready
  );

  modport sink (
    input  valid, run_state, relay_on, seconds_left, mode_now, power_now, completed, status,
    output ready
  );
endinterface

/* rtl/core/cook_timer_duty_cycle_controller_core.sv */
// The result of a command is valid in the cycle after its transaction.
// One command per cycle while rsp.ready is high; the single result register sets the
// pace, and a new command is taken in the cycle its predecessor's result is taken.
// Reset (synchronous, rst high): stopped, 30 s left, window at 0, normal mode,
// 100 % power, relay off, max cook time 1800 s, no result pending.
module cook_timer_duty_cycle_controller_core
  import ctdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ctdc_cmd_if.sink          cmd,
  ctdc_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_data
);

  state_t            state;
  state_t            state_next;
  cmd_t              cmd_in;
  logic [TIME_W-1:0] max_cook;
  logic              out_valid;
  logic              accept;
  logic              step_done;
  logic              step_status;

  assign cmd_in = '{
    opcode:      opcode_t'(cmd.opcode),
    cook_mode:   cmd.cook_mode,
    cook_time:   cmd.cook_time,
    power_level: cmd.power_level,
    power_given: cmd.power_given,
    start_after: cmd.start_after
  };

  // The result register frees up in the same cycle its transaction completes.
  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign rsp.valid = out_valid;

  ctdc_step u_step (
    .st       (state),
    .cmd      (cmd_in),
    .max_cook (max_cook),
    .st_next  (state_next),
    .done     (step_done),
    .status   (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      max_cook  <= MAX_COOK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_cook <= cfg_data;
      end
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.run_state    <= run_code(state_next.run);
      rsp.relay_on     <= state_next.relay;
      rsp.seconds_left <= state_next.remaining;
      rsp.mode_now     <= state_next.mode;
      rsp.power_now    <= state_next.power;
      rsp.completed    <= step_done;
      rsp.status       <= step_status;
    end
  end

endmodule

/* rtl/core/ctdc_step.sv */
module ctdc_step
  import ctdc_pkg::*;
(
  input  state_t             st,
  input  cmd_t               cmd,
  input  logic [TIME_W-1:0]  max_cook,
  output state_t             st_next,
  output logic               done,
  output logic               status
);

  logic [TIME_W-1:0]  time_clamped;
  logic [TIME_W-1:0]  remaining_dec;
  logic [WIN_W-1:0]   pos_inc;
  logic [ONL_W-1:0]   on_limit;
  logic [ONL_W-1:0]   pos_scaled;
  logic [POWER_W-1:0] power_clamped;

  assign time_clamped  = (cmd.cook_time > max_cook) ? max_cook : cmd.cook_time;
  assign power_clamped = (cmd.power_level > POWER_FULL) ? POWER_FULL : cmd.power_level;
  assign remaining_dec = (st.remaining != '0) ? st.remaining - TIME_W'(1) : '0;
  assign pos_inc       = (st.duty_phase == WIN_W'(WINDOW_SEC - 1)) ?
                         '0 : st.duty_phase + WIN_W'(1);

  // The relay is on while pos < round(power * WINDOW_SEC / 100), which is the same as
  // (pos + 1) * 100 <= power * WINDOW_SEC + 50.
  assign on_limit   = ONL_W'(st.power) * ONL_W'(WINDOW_SEC) + ONL_W'(ROUND_HALF);
  assign pos_scaled = (ONL_W'(pos_inc) + ONL_W'(1)) * ONL_W'(PERCENT);

  always_comb begin
    st_next = st;
    done    = 1'b0;
    status  = STATUS_OK;
    case (cmd.opcode)
      OP_TICK: begin
        if (st.run == RS_RUNNING) begin
          st_next.remaining = remaining_dec;
          if (remaining_dec == '0) begin
            done          = 1'b1;
            st_next.run   = RS_STOPPED;
            st_next.relay = 1'b0;
          end else begin
            st_next.duty_phase = pos_inc;
            st_next.relay      = (pos_scaled <= on_limit);
          end
        end
      end
      OP_SET: begin
        st_next.mode      = cmd.cook_mode;
        st_next.remaining = time_clamped;
        if (cmd.power_given) begin
          st_next.power = power_clamped;
        end
        if (cmd.start_after) begin
          st_next.run        = RS_RUNNING;
          st_next.duty_phase = '0;
        end
      end
      OP_MODIFY: begin
        st_next.remaining = time_clamped;
      end
      OP_START, OP_RESUME: begin
        st_next.run        = RS_RUNNING;
        st_next.duty_phase = '0;
      end
      OP_STOP: begin
        st_next.run   = RS_STOPPED;
        st_next.relay = 1'b0;
      end
      OP_PAUSE: begin
        st_next.run   = RS_PAUSED;
        st_next.relay = 1'b0;
      end
      OP_MODE: begin
        if (st.run == RS_RUNNING) begin
          status = STATUS_REJECTED;
        end else begin
          st_next.mode = cmd.cook_mode;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

/* rtl/core/ctdc_checker.sv */
`include "cook_timer_duty_cycle_controller_core_defines.svh"

module ctdc_checker
  import ctdc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         run_state,
  input logic               relay_on,
  input logic [TIME_W-1:0]  seconds_left,
  input logic [POWER_W-1:0] power_now,
  input logic               completed,
  input logic               status
);

  `CTDC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(seconds_left) && $stable(run_state), "stalled result changed")
  `CTDC_ASSERT(a_done_stops, rsp_valid && completed |-> run_state == RUN_CODE_STOPPED && !relay_on && seconds_left == '0, "completion without stop")
  `CTDC_ASSERT(a_reject_running, rsp_valid && status == STATUS_REJECTED |-> run_state == RUN_CODE_RUNNING && !completed, "rejection while not running")
  `CTDC_ASSERT(a_relay_running, rsp_valid && relay_on |-> run_state == RUN_CODE_RUNNING, "relay on outside a running cook")
  `CTDC_ASSERT_ALWAYS(a_power_range, rsp_valid |-> power_now <= POWER_FULL, "power above full scale")

endmodule

bind cook_timer_duty_cycle_controller_core ctdc_checker u_ctdc_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .run_state    (rsp.run_state),
  .relay_on     (rsp.relay_on),
  .seconds_left (rsp.seconds_left),
  .power_now    (rsp.power_now),
  .completed    (rsp.completed),
  .status       (rsp.status)
);
